// ----- src/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/jsc_pkg.sv -----
// Shared constants, types and helper functions of the stick conditioner.
`timescale 1ns / 1ps
package jsc_pkg;

    localparam int AXIS_BITS = 16;
    localparam int AXIS_FRAC = AXIS_BITS - 1;
    localparam int MAG_W     = AXIS_BITS;
    localparam int SQ_W      = 2 * MAG_W;
    localparam int GUARD     = (61 - 2 * AXIS_FRAC) / 2;
    localparam int RAD_IN_W  = SQ_W + 2 * GUARD;
    localparam int RAD_W     = RAD_IN_W / 2;
    localparam int PROD_W    = MAG_W + RAD_W;
    localparam int CSQ_NUM_W = PROD_W - GUARD;
    localparam int CSQ_Q_W   = MAG_W;
    localparam int DZ_W      = AXIS_FRAC;
    localparam int DZ_NUM_W  = MAG_W + AXIS_FRAC;
    localparam int DZ_Q_W    = MAG_W;
    localparam int GAIN_BITS = 16;
    localparam int GAIN_FRAC = 12;
    localparam int GPROD_W   = MAG_W + GAIN_BITS;
    localparam int SAT_IN_W  = GPROD_W - GAIN_FRAC;

    localparam logic [MAG_W-1:0] AXIS_ONE = MAG_W'(1) << AXIS_FRAC;
    localparam logic [DZ_W-1:0]  DZ_CAP   = DZ_W'((99 * (1 << AXIS_FRAC)) / 100);
    localparam logic [DZ_W-1:0]  DZ_RESET = DZ_W'(((((1 << AXIS_FRAC) * 2) / 10) + 1) / 2);

    localparam int NUM_AXES   = 4;
    localparam int NUM_STICKS = 2;
    localparam int REG_IDX_W  = 3;
    localparam int ADDR_W     = REG_IDX_W + 2;
    localparam int APB_DATA_W = 32;
    localparam int IN_DATA_W  = NUM_AXES * (AXIS_BITS + GAIN_BITS);
    localparam int OUT_DATA_W = NUM_AXES * AXIS_BITS;

    // stick lane: magnitude, square, sum, root, product, divide, saturate
    localparam int STICK_LAT = 3 + RAD_W + 1 + CSQ_Q_W + 1;
    // axis lane: threshold setup, divide, gain product, saturate
    localparam int AXIS_LAT  = 1 + DZ_Q_W + 2;
    localparam int PIPE_LAT  = 1 + STICK_LAT + AXIS_LAT;

    typedef logic signed [AXIS_BITS-1:0] t_axis;
    typedef logic signed [GAIN_BITS-1:0] t_gain;
    typedef logic [MAG_W-1:0]            t_mag;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_DZ_LX   = 3'd0,
        REG_DZ_LY   = 3'd1,
        REG_DZ_RX   = 3'd2,
        REG_DZ_RY   = 3'd3,
        REG_SHAPE_L = 3'd4,
        REG_SHAPE_R = 3'd5
    } t_reg_idx;

    function automatic t_mag axis_mag(t_axis v);
        logic [AXIS_BITS:0] e;
        e = {v[AXIS_BITS-1], v};
        if (v[AXIS_BITS-1]) begin
            e = -e;
        end
        return e[MAG_W-1:0];
    endfunction

    function automatic logic [GAIN_BITS-1:0] gain_mag(t_gain g);
        logic [GAIN_BITS:0] e;
        e = {g[GAIN_BITS-1], g};
        if (g[GAIN_BITS-1]) begin
            e = -e;
        end
        return e[GAIN_BITS-1:0];
    endfunction

    // Restore the sign and clamp to the Q1.15 range.
    function automatic t_axis sat_axis(logic neg, logic [SAT_IN_W-1:0] m);
        logic [SAT_IN_W-1:0] one;
        logic [SAT_IN_W-1:0] lim;
        t_axis r;
        one = SAT_IN_W'(AXIS_ONE);
        lim = one - SAT_IN_W'(1);
        if (neg) begin
            if (m >= one) begin
                r = {1'b1, {AXIS_FRAC{1'b0}}};
            end else begin
                r = AXIS_BITS'(SAT_IN_W'(0) - m);
            end
        end else begin
            if (m > lim) begin
                r = {1'b0, {AXIS_FRAC{1'b1}}};
            end else begin
                r = AXIS_BITS'(m);
            end
        end
        return r;
    endfunction

endpackage

// ----- src/jsc_sqrt.sv -----
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
module jsc_sqrt import jsc_pkg::*; #(
    parameter int IN_W   = RAD_IN_W,
    parameter int SIDE_W = 1
) (
    input  logic                i_clk,
    input  logic                i_ce,
    input  logic [IN_W-1:0]     i_num,
    input  logic [SIDE_W-1:0]   i_side,
    output logic [IN_W/2-1:0]   o_root,
    output logic [SIDE_W-1:0]   o_side
);
    localparam int OUT_W = IN_W / 2;

    logic [OUT_W-1:0]  r_root [OUT_W];
    logic [SIDE_W-1:0] r_side [OUT_W];
    logic [OUT_W-1:0]  r_rem  [OUT_W-1];
    logic [IN_W-1:0]   r_num  [OUT_W-1];

    for (genvar k = 0; k < OUT_W; k++) begin : g_stage
        logic [OUT_W-1:0]  rem_in;
        logic [OUT_W-1:0]  root_in;
        logic [IN_W-1:0]   num_in;
        logic [SIDE_W-1:0] side_in;
        logic [OUT_W+1:0]  rem_sh;
        logic [OUT_W+1:0]  trial;
        logic              fit;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign num_in  = i_num;
            assign side_in = i_side;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign num_in  = r_num[k-1];
            assign side_in = r_side[k-1];
        end

        // bring down the next bit pair and try root*4+1
        assign rem_sh = {rem_in, num_in[IN_W-1 -: 2]};
        assign trial  = {root_in, 2'b01};
        assign fit    = rem_sh >= trial;

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_root[k] <= {root_in[OUT_W-2:0], fit};
                r_side[k] <= side_in;
            end
        end

        if (k < OUT_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_rem[k] <= fit ? OUT_W'(rem_sh - trial) : OUT_W'(rem_sh);
                    r_num[k] <= {num_in[IN_W-3:0], 2'b00};
                end
            end
        end
    end

    assign o_root = r_root[OUT_W-1];
    assign o_side = r_side[OUT_W-1];

endmodule

// ----- src/jsc_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module jsc_div import jsc_pkg::*; #(
    parameter int NUM_W  = DZ_NUM_W,
    parameter int DEN_W  = MAG_W,
    parameter int Q_W    = DZ_Q_W,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_ce,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic [Q_W-1:0]    o_quo,
    output logic [SIDE_W-1:0] o_side
);
    // quotient is known to fit Q_W bits, so the top part starts below the divisor
    localparam int HI_W = NUM_W - Q_W;

    logic [Q_W-1:0]    r_q    [Q_W];
    logic [SIDE_W-1:0] r_side [Q_W];
    logic [DEN_W-1:0]  r_rem  [Q_W-1];
    logic [Q_W-1:0]    r_low  [Q_W-1];
    logic [DEN_W-1:0]  r_den  [Q_W-1];

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic [DEN_W-1:0]  rem_in;
        logic [Q_W-1:0]    low_in;
        logic [DEN_W-1:0]  den_in;
        logic [Q_W-1:0]    q_in;
        logic [SIDE_W-1:0] side_in;
        logic [DEN_W:0]    rem_sh;
        logic [DEN_W:0]    diff;
        logic              fit;

        if (k == 0) begin : g_first
            assign rem_in  = DEN_W'(i_num[NUM_W-1 -: HI_W]);
            assign low_in  = i_num[Q_W-1:0];
            assign den_in  = i_den;
            assign q_in    = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign low_in  = r_low[k-1];
            assign den_in  = r_den[k-1];
            assign q_in    = r_q[k-1];
            assign side_in = r_side[k-1];
        end

        assign rem_sh = {rem_in, low_in[Q_W-1]};
        assign diff   = rem_sh - {1'b0, den_in};
        assign fit    = rem_sh >= {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_q[k]    <= {q_in[Q_W-2:0], fit};
                r_side[k] <= side_in;
            end
        end

        if (k < Q_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_rem[k] <= fit ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                    r_low[k] <= {low_in[Q_W-2:0], 1'b0};
                    r_den[k] <= den_in;
                end
            end
        end
    end

    assign o_quo  = r_q[Q_W-1];
    assign o_side = r_side[Q_W-1];

endmodule

// ----- src/jsc_stick_lane.sv -----
// Circle-to-square lane for one stick: radius, ratio and clamp, or pass-through when the mode is off.
`timescale 1ns / 1ps
module jsc_stick_lane import jsc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_ce,
    input  logic  i_mode,
    input  t_axis i_x,
    input  t_axis i_y,
    output t_axis o_x,
    output t_axis o_y
);
    localparam int RT_SIDE_W = 1 + 2 * AXIS_BITS + 3 * MAG_W;
    localparam int DX_SIDE_W = 2 + AXIS_BITS;
    localparam int DY_SIDE_W = AXIS_BITS;

    // magnitude stage
    logic  r1_mode;
    t_axis r1_x, r1_y;
    t_mag  r1_ax, r1_ay, r1_m;
    // square stage
    logic  r2_mode;
    t_axis r2_x, r2_y;
    t_mag  r2_ax, r2_ay, r2_m;
    logic [SQ_W-1:0] r2_sqx, r2_sqy;
    // sum stage
    logic  r3_mode;
    t_axis r3_x, r3_y;
    t_mag  r3_ax, r3_ay, r3_m;
    logic [SQ_W-1:0] r3_sum;
    // product stage
    logic  r4_mode, r4_zero;
    t_axis r4_x, r4_y;
    t_mag  r4_m;
    logic [PROD_W-1:0] r4_px, r4_py;
    // result stage
    t_axis r5_x, r5_y;

    logic [RAD_W-1:0]     w_root;
    logic [RT_SIDE_W-1:0] w_rt_side;
    logic                 w_rt_mode;
    t_axis                w_rt_x, w_rt_y;
    t_mag                 w_rt_ax, w_rt_ay, w_rt_m;
    logic [CSQ_Q_W-1:0]   w_qx, w_qy;
    logic [DX_SIDE_W-1:0] w_dx_side;
    logic [DY_SIDE_W-1:0] w_dy_side;
    logic                 w_d_mode, w_d_zero;
    t_axis                w_d_x, w_d_y;
    t_mag                 w_ax, w_ay;

    assign w_ax = axis_mag(i_x);
    assign w_ay = axis_mag(i_y);

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1_mode <= i_mode;
            r1_x    <= i_x;
            r1_y    <= i_y;
            r1_ax   <= w_ax;
            r1_ay   <= w_ay;
            r1_m    <= (w_ax > w_ay) ? w_ax : w_ay;

            r2_mode <= r1_mode;
            r2_x    <= r1_x;
            r2_y    <= r1_y;
            r2_ax   <= r1_ax;
            r2_ay   <= r1_ay;
            r2_m    <= r1_m;
            r2_sqx  <= r1_ax * r1_ax;
            r2_sqy  <= r1_ay * r1_ay;

            r3_mode <= r2_mode;
            r3_x    <= r2_x;
            r3_y    <= r2_y;
            r3_ax   <= r2_ax;
            r3_ay   <= r2_ay;
            r3_m    <= r2_m;
            r3_sum  <= r2_sqx + r2_sqy;
        end
    end

    jsc_sqrt #(
        .IN_W   (RAD_IN_W),
        .SIDE_W (RT_SIDE_W)
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_ce   (i_ce),
        .i_num  ({r3_sum, {(2 * GUARD){1'b0}}}),
        .i_side ({r3_mode, r3_x, r3_y, r3_ax, r3_ay, r3_m}),
        .o_root (w_root),
        .o_side (w_rt_side)
    );

    assign {w_rt_mode, w_rt_x, w_rt_y, w_rt_ax, w_rt_ay, w_rt_m} = w_rt_side;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r4_mode <= w_rt_mode;
            r4_zero <= (w_rt_m == '0);
            r4_x    <= w_rt_x;
            r4_y    <= w_rt_y;
            r4_m    <= w_rt_m;
            r4_px   <= w_rt_ax * w_root;
            r4_py   <= w_rt_ay * w_root;
        end
    end

    // drop the guard bits before dividing by the larger magnitude
    jsc_div #(
        .NUM_W  (CSQ_NUM_W),
        .DEN_W  (MAG_W),
        .Q_W    (CSQ_Q_W),
        .SIDE_W (DX_SIDE_W)
    ) u_div_x (
        .i_clk  (i_clk),
        .i_ce   (i_ce),
        .i_num  (r4_px[PROD_W-1:GUARD]),
        .i_den  (r4_m),
        .i_side ({r4_mode, r4_zero, r4_x}),
        .o_quo  (w_qx),
        .o_side (w_dx_side)
    );

    jsc_div #(
        .NUM_W  (CSQ_NUM_W),
        .DEN_W  (MAG_W),
        .Q_W    (CSQ_Q_W),
        .SIDE_W (DY_SIDE_W)
    ) u_div_y (
        .i_clk  (i_clk),
        .i_ce   (i_ce),
        .i_num  (r4_py[PROD_W-1:GUARD]),
        .i_den  (r4_m),
        .i_side (r4_y),
        .o_quo  (w_qy),
        .o_side (w_dy_side)
    );

    assign {w_d_mode, w_d_zero, w_d_x} = w_dx_side;
    assign w_d_y = w_dy_side;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            if (!w_d_mode) begin
                r5_x <= w_d_x;
                r5_y <= w_d_y;
            end else if (w_d_zero) begin
                r5_x <= '0;
                r5_y <= '0;
            end else begin
                r5_x <= sat_axis(w_d_x[AXIS_BITS-1], SAT_IN_W'(w_qx));
                r5_y <= sat_axis(w_d_y[AXIS_BITS-1], SAT_IN_W'(w_qy));
            end
        end
    end

    assign o_x = r5_x;
    assign o_y = r5_y;

endmodule

// ----- src/jsc_axis_lane.sv -----
// Per-axis lane: scaled dead zone, then gain with saturation.
`timescale 1ns / 1ps
module jsc_axis_lane import jsc_pkg::*; (
    input  logic            i_clk,
    input  logic            i_ce,
    input  t_axis           i_v,
    input  logic [DZ_W-1:0] i_dz,
    input  t_gain           i_gain,
    output t_axis           o_v
);
    localparam int SIDE_W = 2 + GAIN_BITS;

    t_mag                w_a;
    logic [DZ_W-1:0]     w_dz;
    t_mag                w_diff;

    logic [DZ_NUM_W-1:0] r1_num;
    t_mag                r1_den;
    logic                r1_below, r1_neg;
    t_gain               r1_gain;

    logic [DZ_Q_W-1:0]   w_q;
    logic [SIDE_W-1:0]   w_side;
    logic                w_below, w_neg;
    t_gain               w_gain;
    logic [DZ_Q_W-1:0]   w_d;

    logic [GPROD_W-1:0]  r2_prod;
    logic                r2_neg;
    t_axis               r3_v;

    assign w_a    = axis_mag(i_v);
    assign w_dz   = (i_dz > DZ_CAP) ? DZ_CAP : i_dz;
    assign w_diff = w_a - MAG_W'(w_dz);

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1_num   <= {w_diff, {AXIS_FRAC{1'b0}}};
            r1_den   <= AXIS_ONE - MAG_W'(w_dz);
            r1_below <= w_a < MAG_W'(w_dz);
            r1_neg   <= i_v[AXIS_BITS-1];
            r1_gain  <= i_gain;
        end
    end

    jsc_div #(
        .NUM_W  (DZ_NUM_W),
        .DEN_W  (MAG_W),
        .Q_W    (DZ_Q_W),
        .SIDE_W (SIDE_W)
    ) u_div (
        .i_clk  (i_clk),
        .i_ce   (i_ce),
        .i_num  (r1_num),
        .i_den  (r1_den),
        .i_side ({r1_below, r1_neg, r1_gain}),
        .o_quo  (w_q),
        .o_side (w_side)
    );

    assign {w_below, w_neg, w_gain} = w_side;
    // inside the threshold the axis drops to zero
    assign w_d = w_below ? '0 : w_q;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r2_prod <= w_d * gain_mag(w_gain);
            r2_neg  <= w_neg ^ w_gain[GAIN_BITS-1];
            r3_v    <= sat_axis(r2_neg, r2_prod[GPROD_W-1:GAIN_FRAC]);
        end
    end

    assign o_v = r3_v;

endmodule

// ----- src/joystick_stick_conditioner.sv -----
// Throughput: one transaction per cycle while the master side takes results; the whole
// pipeline holds when a result waits. Depth is set by the 31-stage square root and the
// 16-stage dividers in the stick and axis lanes.
// Reset (synchronous, active low) empties the pipeline and loads the register defaults.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module joystick_stick_conditioner import jsc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // left_x, left_y, right_x, right_y, gain_left_x, gain_left_y, gain_right_x, gain_right_y
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // use_remote
    input  logic                  s_axis_tuser,
    // master stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // out_left_x, out_left_y, out_right_x, out_right_y
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);
    logic [DZ_W-1:0]               r_dz    [NUM_AXES];
    logic [NUM_STICKS-1:0]         r_shape;
    logic [PIPE_LAT-1:0]           r_vld;
    t_axis                         r_in_ax [NUM_AXES];
    logic [NUM_AXES*GAIN_BITS-1:0] r_in_gain;
    logic [NUM_AXES*GAIN_BITS-1:0] r_gain_dly [STICK_LAT];

    logic                          w_ce;
    logic                          w_wr;
    t_reg_idx                      w_idx;
    t_axis                         w_stick [NUM_AXES];
    t_axis                         w_out   [NUM_AXES];

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                r_dz[i] <= DZ_RESET;
            end
            r_shape <= '1;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_DZ_LX:   r_dz[0]    <= pwdata[DZ_W-1:0];
                REG_DZ_LY:   r_dz[1]    <= pwdata[DZ_W-1:0];
                REG_DZ_RX:   r_dz[2]    <= pwdata[DZ_W-1:0];
                REG_DZ_RY:   r_dz[3]    <= pwdata[DZ_W-1:0];
                REG_SHAPE_L: r_shape[0] <= pwdata[0];
                REG_SHAPE_R: r_shape[1] <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_DZ_LX:   prdata = APB_DATA_W'(r_dz[0]);
            REG_DZ_LY:   prdata = APB_DATA_W'(r_dz[1]);
            REG_DZ_RX:   prdata = APB_DATA_W'(r_dz[2]);
            REG_DZ_RY:   prdata = APB_DATA_W'(r_dz[3]);
            REG_SHAPE_L: prdata = APB_DATA_W'(r_shape[0]);
            REG_SHAPE_R: prdata = APB_DATA_W'(r_shape[1]);
            default:     prdata = '0;
        endcase
    end

    // advance every stage unless a finished result is still waiting
    assign w_ce          = !r_vld[PIPE_LAT-1] || m_axis_tready;
    assign s_axis_tready = w_ce;
    assign m_axis_tvalid = r_vld[PIPE_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_ce) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                r_in_ax[i] <= s_axis_tuser ? s_axis_tdata[AXIS_BITS*i +: AXIS_BITS] : '0;
            end
            r_in_gain     <= s_axis_tdata[NUM_AXES*AXIS_BITS +: NUM_AXES*GAIN_BITS];
            r_gain_dly[0] <= r_in_gain;
            for (int j = 1; j < STICK_LAT; j++) begin
                r_gain_dly[j] <= r_gain_dly[j-1];
            end
        end
    end

    for (genvar s = 0; s < NUM_STICKS; s++) begin : g_stick
        jsc_stick_lane u_stick (
            .i_clk  (i_clk),
            .i_ce   (w_ce),
            .i_mode (r_shape[s]),
            .i_x    (r_in_ax[2*s]),
            .i_y    (r_in_ax[2*s+1]),
            .o_x    (w_stick[2*s]),
            .o_y    (w_stick[2*s+1])
        );
    end

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
        jsc_axis_lane u_axis (
            .i_clk  (i_clk),
            .i_ce   (w_ce),
            .i_v    (w_stick[a]),
            .i_dz   (r_dz[a]),
            .i_gain (r_gain_dly[STICK_LAT-1][GAIN_BITS*a +: GAIN_BITS]),
            .o_v    (w_out[a])
        );
        // merge the lane results into one transaction
        assign m_axis_tdata[AXIS_BITS*a +: AXIS_BITS] = w_out[a];
    end

    `ASSERT_PROP(a_accept_enters, i_clk, i_rst_n, (s_axis_tvalid && s_axis_tready) |=> r_vld[0], "accepted transaction did not enter the pipeline")
    `ASSERT_PROP(a_hold_on_stall, i_clk, i_rst_n, !w_ce |=> $stable(r_vld), "pipeline moved while stalled")
    `ASSERT_ALWAYS(a_empty_after_reset, i_clk, $rose(i_rst_n) |-> !m_axis_tvalid, "result valid right after reset")

endmodule
